>>> rtl/core/lsrra_pkg.sv
// shared types and codes for the list store block
// no dependencies
package lsrra_pkg;

   localparam int DATA_W        = 32;
   localparam int CNT_W         = 7;
   localparam int OP_W          = 2;
   localparam int ST_W          = 2;
   localparam int DEPTH_DEFAULT = 64;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [OP_W-1:0]          op_type;
   typedef logic [ST_W-1:0]          status_type;

   localparam op_type OP_APPEND  = 2'd0;
   localparam op_type OP_REPLACE = 2'd1;
   localparam op_type OP_REMOVE  = 2'd2;
   localparam op_type OP_DUMP    = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

endpackage

>>> rtl/core/lsrra_mem.sv
// element storage: one write port, one read port with registered read data
// depends on lsrra_pkg
module lsrra_mem #(
   parameter int DEPTH = lsrra_pkg::DEPTH_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  lsrra_pkg::data_type wr_data,
   input  logic [AW-1:0]     rd_addr,
   output lsrra_pkg::data_type rd_data
);
   import lsrra_pkg::*;

   data_type mem [DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/list_store_replace_remove_all_top.sv
// list store top: command sequencer, element count and result register
// depends on lsrra_pkg and lsrra_mem
//
//   channel   handshake              beat
//   req       start / busy           req_operation, req_first_value, req_second_value
//   rsp       rsp_strobe (no stall)  rsp_element, rsp_count, rsp_status, rsp_last
//
// append, and any command on an empty list: result in the cycle after
// acceptance, busy stays low.
// replace, remove and dump walk the stored elements through the single
// memory read port, one per cycle, with busy high for the walk; dump beats
// stream one per cycle, the last beat in the first cycle with busy low.
// the receiver cannot stall; reset clears the element count, memory is never cleared.
module list_store_replace_remove_all_top #(
   parameter int DEPTH = lsrra_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lsrra_pkg::op_type      req_operation,
   input  lsrra_pkg::data_type    req_first_value,
   input  lsrra_pkg::data_type    req_second_value,
   output logic                   rsp_strobe,
   output lsrra_pkg::data_type    rsp_element,
   output lsrra_pkg::cnt_type     rsp_count,
   output lsrra_pkg::status_type  rsp_status,
   output logic                   rsp_last
);
   import lsrra_pkg::*;

   localparam int      AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam cnt_type DEPTH_CNT = CNT_W'(DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WALK = 1'b1;

   logic       state_ff, state_in;
   cnt_type    count_ff, count_in;
   cnt_type    rd_idx_ff, rd_idx_in;
   cnt_type    pend_idx_ff, pend_idx_in;
   logic       pend_ff, pend_in;
   cnt_type    keep_ff, keep_in;
   op_type     op_ff, op_in;
   data_type   match_ff, match_in;
   data_type   repl_ff, repl_in;

   logic       rsp_strobe_ff, rsp_strobe_in;
   data_type   rsp_element_ff, rsp_element_in;
   cnt_type    rsp_count_ff, rsp_count_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   data_type      wr_data;
   logic [AW-1:0] rd_addr;
   data_type      rd_data;

   logic accept;
   logic pend_is_last;
   logic is_match;

   lsrra_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy         = (state_ff == S_WALK);
   assign accept       = start && !busy;
   assign pend_is_last = (CNT_W'(pend_idx_ff + 7'd1) == count_ff);
   assign is_match     = (rd_data == match_ff);
   assign rd_addr      = rd_idx_ff[AW-1:0];

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rd_idx_in      = rd_idx_ff;
      pend_idx_in    = pend_idx_ff;
      pend_in        = 1'b0;
      keep_in        = keep_ff;
      op_in          = op_ff;
      match_in       = match_ff;
      repl_in        = repl_ff;
      rsp_strobe_in  = 1'b0;
      rsp_element_in = '0;
      rsp_count_in   = count_ff;
      rsp_status_in  = ST_OK;
      rsp_last_in    = 1'b1;
      wr_en          = 1'b0;
      wr_addr        = count_ff[AW-1:0];
      wr_data        = req_first_value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               match_in = req_first_value;
               repl_in  = req_second_value;
               if (req_operation == OP_APPEND) begin
                  rsp_strobe_in = 1'b1;
                  if (count_ff >= DEPTH_CNT) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     wr_en        = 1'b1;
                     count_in     = CNT_W'(count_ff + 7'd1);
                     rsp_count_in = CNT_W'(count_ff + 7'd1);
                  end
               end else if (count_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  if (req_operation == OP_DUMP) begin
                     rsp_status_in = ST_EMPTY;
                  end
               end else begin
                  state_in  = S_WALK;
                  rd_idx_in = '0;
                  keep_in   = '0;
               end
            end
         end
         S_WALK: begin
            if (rd_idx_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff;
               rd_idx_in   = CNT_W'(rd_idx_ff + 7'd1);
            end
            if (pend_ff) begin
               priority case (op_ff)
                  OP_DUMP: begin
                     rsp_strobe_in  = 1'b1;
                     rsp_element_in = rd_data;
                     rsp_last_in    = pend_is_last;
                  end
                  OP_REPLACE: begin
                     wr_en   = is_match;
                     wr_addr = pend_idx_ff[AW-1:0];
                     wr_data = repl_ff;
                  end
                  default: begin
                     wr_en   = !is_match;
                     wr_addr = keep_ff[AW-1:0];
                     wr_data = rd_data;
                     if (!is_match) begin
                        keep_in = CNT_W'(keep_ff + 7'd1);
                     end
                  end
               endcase
               if (pend_is_last) begin
                  state_in = S_IDLE;
                  if (op_ff != OP_DUMP) begin
                     rsp_strobe_in = 1'b1;
                     if (op_ff == OP_REMOVE) begin
                        count_in     = keep_in;
                        rsp_count_in = keep_in;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      pend_idx_ff    <= pend_idx_in;
      keep_ff        <= keep_in;
      op_ff          <= op_in;
      match_ff       <= match_in;
      repl_ff        <= repl_in;
      rsp_element_ff <= rsp_element_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

>>> tb/sv/list_store_replace_remove_all_top_tb.sv
// testbench for the list store block: directed command table, then random command mix
// checks every result beat against a typed beat from the table or a shadow list kept in the testbench
// depends on lsrra_pkg and list_store_replace_remove_all_top
module list_store_replace_remove_all_top_tb;
   import lsrra_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 215;
   localparam int IDLE_LIMIT   = 2000;
   localparam int MAX_GAP      = 13;
   localparam int TAIL_CYCLES  = 80;

   typedef struct packed {
      data_type   element;
      cnt_type    count;
      status_type status;
      logic       last;
   } list_beat_type;

   typedef struct packed {
      op_type        op;
      data_type      first;
      data_type      second;
      logic [6:0]    reps;
      logic          typed;
      list_beat_type beat;
   } dir_row_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   op_type     req_operation;
   data_type   req_first_value;
   data_type   req_second_value;
   logic       rsp_strobe;
   data_type   rsp_element;
   cnt_type    rsp_count;
   status_type rsp_status;
   logic       rsp_last;

   data_type      shadow_elems [LIST_DEPTH];
   int            shadow_count;
   list_beat_type step_beats [$];
   list_beat_type expected_beats [$];
   dir_row_type   dir_rows [$];
   data_type      value_pool [8];
   int            mismatches;
   int            idle_cycles;
   bit            no_idle;

   list_store_replace_remove_all_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_element      (rsp_element),
      .rsp_count        (rsp_count),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic list_beat_type make_beat(input data_type e, input int c,
                                               input status_type s, input logic l);
      list_beat_type b;
      b.element = e;
      b.count   = cnt_type'(c);
      b.status  = s;
      b.last    = l;
      return b;
   endfunction

   function automatic void apply_command(input op_type op, input data_type a,
                                         input data_type b);
      int k;
      step_beats.delete();
      case (op)
         OP_APPEND: begin
            if (shadow_count >= LIST_DEPTH) begin
               step_beats.push_back(make_beat('0, shadow_count, ST_FULL, 1'b1));
            end else begin
               shadow_elems[shadow_count] = a;
               shadow_count++;
               step_beats.push_back(make_beat('0, shadow_count, ST_OK, 1'b1));
            end
         end
         OP_REPLACE: begin
            for (int i = 0; i < shadow_count; i++)
               if (shadow_elems[i] == a) shadow_elems[i] = b;
            step_beats.push_back(make_beat('0, shadow_count, ST_OK, 1'b1));
         end
         OP_REMOVE: begin
            k = 0;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_elems[i] != a) begin
                  shadow_elems[k] = shadow_elems[i];
                  k++;
               end
            end
            shadow_count = k;
            step_beats.push_back(make_beat('0, shadow_count, ST_OK, 1'b1));
         end
         default: begin
            if (shadow_count == 0) begin
               step_beats.push_back(make_beat('0, 0, ST_EMPTY, 1'b1));
            end else begin
               for (int i = 0; i < shadow_count; i++)
                  step_beats.push_back(make_beat(shadow_elems[i], shadow_count, ST_OK,
                                                 (i + 1 == shadow_count)));
            end
         end
      endcase
   endfunction

   task automatic add_row(input op_type op, input data_type a, input data_type b,
                          input int reps, input logic typed, input data_type e,
                          input int c, input status_type s);
      dir_row_type r;
      r.op     = op;
      r.first  = a;
      r.second = b;
      r.reps   = 7'(reps);
      r.typed  = typed;
      r.beat   = make_beat(e, c, s, 1'b1);
      dir_rows.push_back(r);
   endtask

   // one command: idle gap, present, hold until accepted, then predict
   task automatic send_command(input op_type op, input data_type a, input data_type b,
                               input logic typed, input list_beat_type typed_beat);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_operation    <= op;
      req_first_value  <= a;
      req_second_value <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_command(op, a, b);
      if (typed) expected_beats.push_back(typed_beat);
      else foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
   endtask

   function automatic data_type pick_value();
      if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
      return data_type'($urandom);
   endfunction

   // result beats
   always @(posedge clock) begin
      list_beat_type want;
      if (!reset && rsp_strobe) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: element %0d count %0d status %0d last %0b",
                        rsp_element, rsp_count, rsp_status, rsp_last);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_element !== want.element || rsp_count !== want.count ||
                rsp_status !== want.status || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d/%0d/%0b actual %0d/%0d/%0d/%0b",
                           want.element, want.count, want.status, want.last,
                           rsp_element, rsp_count, rsp_status, rsp_last);
            end
         end
      end
   end

   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      data_type      dmin;
      data_type      dmax;
      list_beat_type none;
      dir_row_type   row;
      int            items;
      int            pick;
      int            n;

      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = OP_APPEND;
      req_first_value  = '0;
      req_second_value = '0;
      mismatches       = 0;
      shadow_count     = 0;
      no_idle          = 1'b0;
      dmin             = 32'sh8000_0000;
      dmax             = 32'sh7fff_ffff;
      none             = '0;
      value_pool[0]    = dmin;
      value_pool[1]    = dmax;
      value_pool[2]    = '0;
      value_pool[3]    = -1;
      for (int i = 4; i < 8; i++) value_pool[i] = data_type'($urandom);

      // op, first, second, reps, typed, element, count, status
      add_row(OP_DUMP,    dmax,  dmin,  1, 1, 0, 0,  ST_EMPTY);
      add_row(OP_REPLACE, 0,     1,     1, 1, 0, 0,  ST_OK);
      add_row(OP_REMOVE,  0,     -1,    1, 1, 0, 0,  ST_OK);
      add_row(OP_APPEND,  dmin,  dmax,  1, 1, 0, 1,  ST_OK);
      add_row(OP_APPEND,  dmax,  0,     1, 1, 0, 2,  ST_OK);
      add_row(OP_APPEND,  dmin,  -1,    1, 1, 0, 3,  ST_OK);
      add_row(OP_DUMP,    -1,    -1,    1, 0, 0, 0,  ST_OK);
      add_row(OP_REMOVE,  dmin,  dmax,  1, 1, 0, 1,  ST_OK);
      add_row(OP_DUMP,    0,     0,     1, 0, 0, 0,  ST_OK);
      add_row(OP_REMOVE,  dmax,  0,     1, 1, 0, 0,  ST_OK);
      add_row(OP_DUMP,    dmin,  dmax,  1, 1, 0, 0,  ST_EMPTY);
      add_row(OP_APPEND,  0,     dmin,  1, 1, 0, 1,  ST_OK);
      add_row(OP_APPEND,  -1,    dmax,  1, 1, 0, 2,  ST_OK);
      add_row(OP_APPEND,  1,     -1,    1, 1, 0, 3,  ST_OK);
      add_row(OP_REPLACE, -1,    dmax,  1, 0, 0, 0,  ST_OK);
      add_row(OP_REPLACE, 0,     0,     1, 0, 0, 0,  ST_OK);
      add_row(OP_REPLACE, 42,    7,     1, 0, 0, 0,  ST_OK);
      add_row(OP_REMOVE,  42,    0,     1, 1, 0, 3,  ST_OK);
      add_row(OP_APPEND,  1000,  -1,    61, 0, 0, 0, ST_OK);
      add_row(OP_APPEND,  5,     0,     1, 1, 0, 64, ST_FULL);
      add_row(OP_APPEND,  dmin,  dmin,  1, 1, 0, 64, ST_FULL);
      add_row(OP_REPLACE, 1000,  dmin,  1, 0, 0, 0,  ST_OK);
      add_row(OP_DUMP,    dmax,  dmax,  1, 0, 0, 0,  ST_OK);
      add_row(OP_REMOVE,  1,     dmax,  1, 0, 0, 0,  ST_OK);
      add_row(OP_DUMP,    -1,    0,     1, 0, 0, 0,  ST_OK);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[j]) begin
         row = dir_rows[j];
         for (int r = 0; r < int'(row.reps); r++)
            send_command(row.op, row.first + r, row.second, row.typed, row.beat);
      end

      items = 0;
      while (items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            // fill to full and push past it
            n = LIST_DEPTH - shadow_count + $urandom_range(1, 2);
            repeat (n) send_command(OP_APPEND, pick_value(), data_type'($urandom), 0, none);
            items += n;
         end else if (pick < 8) begin
            // sweep the pool out of the list
            foreach (value_pool[i])
               send_command(OP_REMOVE, value_pool[i], data_type'($urandom), 0, none);
            items += 8;
         end else if (pick < 50) begin
            send_command(OP_APPEND, pick_value(), data_type'($urandom), 0, none);
            items++;
         end else if (pick < 68) begin
            send_command(OP_REPLACE, pick_value(), pick_value(), 0, none);
            items++;
         end else if (pick < 82) begin
            send_command(OP_REMOVE, pick_value(), data_type'($urandom), 0, none);
            items++;
         end else begin
            send_command(OP_DUMP, data_type'($urandom), data_type'($urandom), 0, none);
            items++;
         end
      end
      start <= 1'b0;

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/lsrra_pkg.sv
rtl/core/lsrra_mem.sv
rtl/core/list_store_replace_remove_all_top.sv
tb/sv/list_store_replace_remove_all_top_tb.sv
